/* rtl/jcr_pkg.sv */
`default_nettype none

package jcr_pkg;

   // Sizes of the stick and button inputs
   localparam int ADC_BITS   = 12;
   localparam int BUTTONS    = 7;
   localparam int DELTA_W    = ADC_BITS + 1;
   localparam int DIFF_W     = DELTA_W + 1;

   // Configuration register widths
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int THRESH_W   = 13;
   localparam int PERIOD_W   = 20;
   localparam int COUNT_W    = 4;
   localparam int ELAPSED_W  = 16;
   localparam int SINCE_W    = 21;
   localparam int MODE_W     = 2;
   localparam int CHAN_W     = 8;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_THRESH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAME_GAP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PERIOD  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = 3'd6;

   // Register reset values
   localparam logic [ADC_BITS-1:0] CENTER_RESET   = 12'd2048;
   localparam logic [ADC_BITS-1:0] DEADZONE_RESET = 12'd220;
   localparam logic [THRESH_W-1:0] THRESH_RESET   = 13'd14;
   localparam logic [PERIOD_W-1:0] GAP_RESET      = 20'd33000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 20'd25000;
   localparam logic [COUNT_W-1:0]  DEBOUNCE_RESET = 4'd4;

   // Operating modes
   localparam logic [MODE_W-1:0] MODE_SILENT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CAL    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GAME   = 2'd2;

   // Filter and scaling constants
   localparam int FILT_WEIGHT = 7;
   localparam int LP_SHIFT    = 3;
   localparam int SUM_W       = ADC_BITS + LP_SHIFT;
   localparam int COUNT_MAX   = 15;
   localparam logic [SINCE_W-1:0] SINCE_MAX  = {SINCE_W{1'b1}};
   localparam logic [CHAN_W-1:0]  STICK_BLUE = 8'd48;
   localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'd255;

   // Offset scaling: ad * 255 / 500 saturates from SCALE_SAT on; below that
   // it equals (ad * 51) / 100, done as a multiply by ceil(2^21 / 100)
   localparam int SCALE_SAT   = 502;
   localparam int SCALE_NUM   = 51;
   localparam int SCALE_RECIP = 20972;
   localparam int SCALE_SHIFT = 21;

   // Button color table
   localparam int TABLE_LEN = 7;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   // Filtered offset and LED intensity of one axis
   typedef struct packed {
      logic signed [DELTA_W-1:0] delta;
      logic [CHAN_W-1:0]         mag;
   } axis_type;

   // LED color decision for one sample
   typedef struct packed {
      logic    write;
      rgb_type color;
   } led_type;

   function automatic rgb_type key_rgb(input logic [2:0] idx);
      rgb_type c;
      case (idx)
         3'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
         3'd1:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
         3'd2:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
         3'd3:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
         3'd4:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
         3'd5:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
         3'd6:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
         default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/joystick_conditioner_reporter.sv */
// Joystick conditioner and report gate. Each request beat is a stick sample
// (filtered, centered, deadzoned, buttons debounced, LED color chosen) or a
// mode command, and produces exactly one response beat. The block takes one
// beat per clock: a request is held in an input register, processed in one
// pass through the filter, debounce and report-gating logic, and lands in the
// response register, so throughput is one item per cycle. A beat moves from
// the input register to the response register, where it is held until taken;
// only a response held by rsp_ready low stalls the input. Configuration
// registers are written through the csr_ port, one per cycle, and should be
// changed only while no beats are in flight. Index values beyond the register
// list are ignored.

`default_nettype none

module joystick_conditioner_reporter import jcr_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_cmd,
   input  wire logic [ADC_BITS-1:0]        req_raw_x,
   input  wire logic [ADC_BITS-1:0]        req_raw_y,
   input  wire logic                       req_adc_ok,
   input  wire logic [BUTTONS-1:0]         req_raw_buttons,
   input  wire logic [ELAPSED_W-1:0]       req_elapsed_us,
   input  wire logic [MODE_W-1:0]          req_new_mode,

   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_report,
   output logic signed [DELTA_W-1:0]       rsp_delta_x,
   output logic signed [DELTA_W-1:0]       rsp_delta_y,
   output logic [BUTTONS-1:0]              rsp_buttons,
   output logic                            rsp_sample_ok,
   output logic                            rsp_led_write,
   output logic [CHAN_W-1:0]               rsp_led_red,
   output logic [CHAN_W-1:0]               rsp_led_green,
   output logic [CHAN_W-1:0]               rsp_led_blue,

   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers
   logic [ADC_BITS-1:0] center_x_ff, center_y_ff, deadzone_ff;
   logic [THRESH_W-1:0] move_thresh_ff;
   logic [PERIOD_W-1:0] game_gap_ff, cal_period_ff;
   logic [COUNT_W-1:0]  debounce_ff;

   // Input register
   logic                 in_valid_ff;
   logic                 cmd_ff;
   logic [ADC_BITS-1:0]  raw_x_ff, raw_y_ff;
   logic                 adc_ok_ff;
   logic [BUTTONS-1:0]   raw_btn_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [MODE_W-1:0]    new_mode_ff;

   // Report gating state
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic                      sync_ff, sync_in;
   logic signed [DELTA_W-1:0] last_dx_ff, last_dx_in;
   logic signed [DELTA_W-1:0] last_dy_ff, last_dy_in;
   logic [BUTTONS-1:0]        last_mask_ff, last_mask_in;
   logic [SINCE_W-1:0]        since_ff, since_in;

   // Response register
   logic                      out_valid_ff;
   logic                      report_ff;
   logic signed [DELTA_W-1:0] dx_ff, dy_ff;
   logic [BUTTONS-1:0]        buttons_ff;
   logic                      sample_ok_ff;
   logic                      led_write_ff;
   rgb_type                   color_ff;

   logic                      advance;
   logic                      sample;
   logic                      load;
   axis_type                  axis_x, axis_y;
   led_type                   led;
   logic [BUTTONS-1:0]        stable;
   logic signed [DELTA_W-1:0] dx, dy;
   logic signed [DELTA_W-1:0] base_dx, base_dy;
   logic [BUTTONS-1:0]        base_mask;
   logic [SINCE_W:0]          since_sum;
   logic [SINCE_W-1:0]        since_sat, since_base;
   logic                      sync_now;
   logic signed [DIFF_W-1:0]  diff_x, diff_y;
   logic [DIFF_W-1:0]         adiff_x, adiff_y;
   logic                      stick;
   logic                      report;

   // Move a beat from the input register to the response register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign sample    = advance && !cmd_ff;
   assign load      = sample && adc_ok_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= CENTER_RESET;
         center_y_ff    <= CENTER_RESET;
         deadzone_ff    <= DEADZONE_RESET;
         move_thresh_ff <= THRESH_RESET;
         game_gap_ff    <= GAP_RESET;
         cal_period_ff  <= PERIOD_RESET;
         debounce_ff    <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:    center_x_ff    <= csr_wdata[ADC_BITS-1:0];
            CSR_CENTER_Y:    center_y_ff    <= csr_wdata[ADC_BITS-1:0];
            CSR_DEADZONE:    deadzone_ff    <= csr_wdata[ADC_BITS-1:0];
            CSR_MOVE_THRESH: move_thresh_ff <= csr_wdata[THRESH_W-1:0];
            CSR_GAME_GAP:    game_gap_ff    <= csr_wdata[PERIOD_W-1:0];
            CSR_CAL_PERIOD:  cal_period_ff  <= csr_wdata[PERIOD_W-1:0];
            CSR_DEBOUNCE:    debounce_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff      <= req_cmd;
         raw_x_ff    <= req_raw_x;
         raw_y_ff    <= req_raw_y;
         adc_ok_ff   <= req_adc_ok;
         raw_btn_ff  <= req_raw_buttons;
         elapsed_ff  <= req_elapsed_us;
         new_mode_ff <= req_new_mode;
      end
   end

   jcr_axis u_axis_x (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .raw      (raw_x_ff),
      .center   (center_x_ff),
      .deadzone (deadzone_ff),
      .res      (axis_x)
   );

   jcr_axis u_axis_y (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .raw      (raw_y_ff),
      .center   (center_y_ff),
      .deadzone (deadzone_ff),
      .res      (axis_y)
   );

   jcr_debounce u_debounce (
      .clock  (clock),
      .reset  (reset),
      .step   (sample),
      .raw    (raw_btn_ff),
      .reads  (debounce_ff),
      .stable (stable)
   );

   jcr_led u_led (
      .clock  (clock),
      .reset  (reset),
      .step   (sample),
      .mask   (stable),
      .adc_ok (adc_ok_ff),
      .mag_x  (axis_x.mag),
      .mag_y  (axis_y.mag),
      .res    (led)
   );

   // Deltas read zero on a failed ADC read
   assign dx = adc_ok_ff ? axis_x.delta : '0;
   assign dy = adc_ok_ff ? axis_y.delta : '0;

   // Accumulate time, saturating
   always_comb begin
      since_sum = {1'b0, since_ff} + (SINCE_W + 1)'(elapsed_ff);
      since_sat = since_sum[SINCE_W] ? SINCE_MAX : since_sum[SINCE_W-1:0];
   end

   // Sync the shadow values on game entry, then gate the report
   always_comb begin
      sync_now   = sync_ff && (mode_ff == MODE_GAME);
      base_dx    = sync_now ? dx : last_dx_ff;
      base_dy    = sync_now ? dy : last_dy_ff;
      base_mask  = sync_now ? stable : last_mask_ff;
      since_base = sync_now ? '0 : since_sat;

      diff_x  = DIFF_W'(dx) - DIFF_W'(base_dx);
      diff_y  = DIFF_W'(dy) - DIFF_W'(base_dy);
      adiff_x = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
      adiff_y = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
      stick   = (adiff_x >= DIFF_W'(move_thresh_ff)) ||
                (adiff_y >= DIFF_W'(move_thresh_ff));

      case (mode_ff)
         MODE_CAL:  report = since_base >= SINCE_W'(cal_period_ff);
         MODE_GAME: report = (stable != base_mask) ||
                             (stick && since_base >= SINCE_W'(game_gap_ff));
         default:   report = 1'b0;
      endcase
   end

   // Next gating state for a sample or a mode command
   always_comb begin
      mode_in      = mode_ff;
      sync_in      = sync_ff;
      last_dx_in   = last_dx_ff;
      last_dy_in   = last_dy_ff;
      last_mask_in = last_mask_ff;
      since_in     = since_ff;
      if (advance) begin
         if (cmd_ff) begin
            case (new_mode_ff)
               MODE_SILENT: mode_in = MODE_SILENT;
               MODE_CAL: begin
                  mode_in  = MODE_CAL;
                  sync_in  = 1'b0;
                  since_in = SINCE_MAX;
               end
               MODE_GAME: begin
                  mode_in = MODE_GAME;
                  sync_in = 1'b1;
               end
               default: ;
            endcase
         end else begin
            sync_in      = sync_now ? 1'b0 : sync_ff;
            last_dx_in   = report ? dx : base_dx;
            last_dy_in   = report ? dy : base_dy;
            last_mask_in = report ? stable : base_mask;
            since_in     = report ? '0 : since_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SILENT;
         sync_ff      <= 1'b0;
         last_dx_ff   <= '0;
         last_dy_ff   <= '0;
         last_mask_ff <= '0;
         since_ff     <= SINCE_MAX;
      end else begin
         mode_ff      <= mode_in;
         sync_ff      <= sync_in;
         last_dx_ff   <= last_dx_in;
         last_dy_ff   <= last_dy_in;
         last_mask_ff <= last_mask_in;
         since_ff     <= since_in;
      end
   end

   // Hold the response beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         report_ff    <= sample && report;
         dx_ff        <= cmd_ff ? '0 : dx;
         dy_ff        <= cmd_ff ? '0 : dy;
         buttons_ff   <= stable;
         sample_ok_ff <= !cmd_ff && adc_ok_ff;
         led_write_ff <= led.write;
         color_ff     <= led.color;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_report    = report_ff;
   assign rsp_delta_x   = dx_ff;
   assign rsp_delta_y   = dy_ff;
   assign rsp_buttons   = buttons_ff;
   assign rsp_sample_ok = sample_ok_ff;
   assign rsp_led_write = led_write_ff;
   assign rsp_led_red   = color_ff.red;
   assign rsp_led_green = color_ff.green;
   assign rsp_led_blue  = color_ff.blue;

endmodule

`default_nettype wire

/* rtl/jcr_axis.sv */
`default_nettype none

module jcr_axis import jcr_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic [ADC_BITS-1:0] raw,
   input  wire logic [ADC_BITS-1:0] center,
   input  wire logic [ADC_BITS-1:0] deadzone,
   output axis_type                 res
);

   logic [ADC_BITS-1:0]        filt_ff, filt_in;
   logic                       seeded_ff, seeded_in;
   logic [SUM_W-1:0]           sum;
   logic [ADC_BITS-1:0]        filt_next;
   logic signed [DELTA_W-1:0]  d;
   logic [DELTA_W-1:0]         ad;
   logic [15:0]                ad_wide;
   logic [14:0]                num;
   logic [29:0]                prod;
   logic signed [DELTA_W-1:0]  delta;
   logic [CHAN_W-1:0]          mag;

   // Low-pass step, seeded by the first good sample
   always_comb begin
      sum       = SUM_W'(filt_ff) * SUM_W'(FILT_WEIGHT) + SUM_W'(raw);
      filt_next = seeded_ff ? sum[SUM_W-1:LP_SHIFT] : raw;
      filt_in   = load ? filt_next : filt_ff;
      seeded_in = seeded_ff | load;
   end

   // Offset from center with symmetric deadzone
   always_comb begin
      d     = $signed({1'b0, filt_next}) - $signed({1'b0, center});
      ad    = d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
      delta = (ad < {1'b0, deadzone}) ? '0 : d;
   end

   // Scale the offset magnitude to an LED channel
   always_comb begin
      ad_wide = 16'(ad);
      num     = 15'(ad_wide[8:0]) * 15'(SCALE_NUM);
      prod    = 30'(num) * 30'(SCALE_RECIP);
      if (ad_wide >= 16'(SCALE_SAT)) begin
         mag = CHAN_MAX;
      end else begin
         mag = prod[SCALE_SHIFT+CHAN_W-1:SCALE_SHIFT];
      end
   end

   assign res = '{delta: delta, mag: mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff   <= '0;
         seeded_ff <= 1'b0;
      end else begin
         filt_ff   <= filt_in;
         seeded_ff <= seeded_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/jcr_debounce.sv */
`default_nettype none

module jcr_debounce import jcr_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [BUTTONS-1:0] raw,
   input  wire logic [COUNT_W-1:0] reads,
   output logic      [BUTTONS-1:0] stable
);

   logic [BUTTONS-1:0] cand_ff, cand_in;
   logic [BUTTONS-1:0] stable_ff, stable_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Count equal masks, restart on a change, accept once enough are seen
   always_comb begin
      cand_in   = cand_ff;
      count_in  = count_ff;
      stable_in = stable_ff;
      if (step) begin
         if (raw == cand_ff) begin
            if (count_ff != COUNT_W'(COUNT_MAX)) begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            cand_in  = raw;
            count_in = COUNT_W'(1);
         end
         if (count_in >= reads) begin
            stable_in = cand_in;
         end
      end
   end

   assign stable = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff   <= '0;
         count_ff  <= '0;
         stable_ff <= '0;
      end else begin
         cand_ff   <= cand_in;
         count_ff  <= count_in;
         stable_ff <= stable_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/jcr_led.sv */
`default_nettype none

module jcr_led import jcr_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [BUTTONS-1:0] mask,
   input  wire logic               adc_ok,
   input  wire logic [CHAN_W-1:0]  mag_x,
   input  wire logic [CHAN_W-1:0]  mag_y,
   output led_type                 res
);

   rgb_type last_ff, last_in;
   logic    seeded_ff, seeded_in;
   rgb_type color;
   logic    have;
   logic    write;

   // Pick the lowest pressed button's color, else the stick color
   always_comb begin
      color = '{red: mag_x, green: mag_y, blue: STICK_BLUE};
      have  = adc_ok;
      for (int i = BUTTONS - 1; i >= 0; i--) begin
         if (i < TABLE_LEN && mask[i]) begin
            color = key_rgb(3'(i));
            have  = 1'b1;
         end
      end
   end

   // Rewrite the LED only when the color changes
   always_comb begin
      write     = step && have && (!seeded_ff || color != last_ff);
      last_in   = write ? color : last_ff;
      seeded_in = seeded_ff | write;
      res.write = write;
      res.color = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         seeded_ff <= 1'b0;
      end else begin
         last_ff   <= last_in;
         seeded_ff <= seeded_in;
      end
   end

endmodule

`default_nettype wire
